// File: rtl/kal_pkg.sv
// Shared types and constants of the keyed array list.
`default_nettype none

package kal_pkg;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 64;
  localparam int IDX_W   = 6;
  localparam int OP_W    = 2;
  localparam int ECNT_W  = 7;
  localparam int IN_DW   = 104;
  localparam int OUT_DW  = 104;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Per-slot strobes from the sequencer.
  typedef struct packed {
    logic cmp;    // compare own key against the command key
    logic live;   // slot lies below the entry count
    logic load;   // take the appended entry
    logic shift;  // take the right neighbor's entry
  } slot_ctrl_t;

endpackage : kal_pkg

`default_nettype wire

// File: rtl/kal_cell.sv
// One slot of the list: holds an entry, matches its key, takes its neighbor's entry.
`default_nettype none

module kal_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kal_pkg::slot_ctrl_t         ctrl,
  input  wire logic [kal_pkg::KEY_W-1:0]   cmd_key,
  input  wire kal_pkg::entry_t             load_entry,
  input  wire kal_pkg::entry_t             next_entry,
  output kal_pkg::entry_t                  entry,
  output logic                             match
);
  import kal_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match_r;
  logic   match_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load) begin
      entry_nxt = load_entry;
    end else if (ctrl.shift) begin
      entry_nxt = next_entry;
    end
    match_nxt = ctrl.cmp & ctrl.live & (entry_r.key == cmd_key);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule : kal_cell

`default_nettype wire

// File: rtl/keyed_array_list_unit.sv
// Top level of the keyed array list: sequencer, slot chain and result register.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready | tuser: opcode; tdata: key, payload, index
//  out_    | out | out_tvalid/out_tready| tdata: success, entry_count, key, payload
//
//  An item passes three steps: accept, key compare in every slot (removes only),
//  then apply (load, shift-down or read) with the result in the output register.
//  A new item is accepted only in idle, after the last item's apply step.
//  The apply step waits while the output register holds an untaken result.
//  Reset clears count, state, valid and match flags; slot contents stay undefined.
`default_nettype none

module keyed_array_list_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [31:0] key, [95:32] payload, [101:96] index, [103:102] zero
  input  wire logic [kal_pkg::IN_DW-1:0]     in_tdata,
  // [1:0] opcode
  input  wire logic [kal_pkg::OP_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] success, [7:1] entry_count, [39:8] read_key, [103:40] read_payload
  output logic [kal_pkg::OUT_DW-1:0]         out_tdata
);
  import kal_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SEL_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  op_t                 op_r;
  logic [KEY_W-1:0]    key_r;
  logic [PAY_W-1:0]    pay_r;
  logic [IDX_W-1:0]    idx_r;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;

  slot_ctrl_t          ctrl    [CAPACITY];
  entry_t              slot_q  [CAPACITY];
  entry_t              slot_nx [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] load_vec;
  logic [CAPACITY-1:0] shift_vec;
  logic [CAPACITY-1:0] live_vec;
  logic [CAPACITY-1:0] rd_sel;
  logic [CAPACITY-1:0] below_first;

  logic                in_xfer;
  logic                apply_go;
  logic                found;
  logic                has_room;
  logic                rd_ok;
  logic                ok;
  entry_t              rd_entry;
  entry_t              new_entry;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign apply_go  = (state_r == ST_APPLY) & (~out_tvalid_r | out_tready);

  assign new_entry.key     = key_r;
  assign new_entry.payload = pay_r;

  // Lowest matching slot and everything above it move down one place.
  assign found       = |match_vec;
  assign below_first = (match_vec - CAPACITY'(1)) & ~match_vec;
  assign has_room    = (cnt_r < CNT_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign live_vec[i]  = (CNT_W'(i) < cnt_r);
    assign load_vec[i]  = apply_go & (op_r == OP_APPEND) & has_room & (cnt_r == CNT_W'(i));
    assign shift_vec[i] = apply_go & (op_r == OP_REMOVE) & found & ~below_first[i];
    assign rd_sel[i]    = (op_r == OP_READ) & live_vec[i] & (SEL_W'(idx_r) == SEL_W'(i));

    // Keep comparing while the apply step waits so the match stays valid.
    assign ctrl[i].cmp   = ((state_r == ST_MATCH) | (state_r == ST_APPLY)) &
                           (op_r == OP_REMOVE);
    assign ctrl[i].live  = live_vec[i];
    assign ctrl[i].load  = load_vec[i];
    assign ctrl[i].shift = shift_vec[i];

    if (i == CAPACITY - 1) begin : g_tail
      assign slot_nx[i] = '0;
    end else begin : g_body
      assign slot_nx[i] = slot_q[i+1];
    end

    kal_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl[i]),
      .cmd_key    (key_r),
      .load_entry (new_entry),
      .next_entry (slot_nx[i]),
      .entry      (slot_q[i]),
      .match      (match_vec[i])
    );
  end

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_entry = rd_entry | (slot_q[i] & {$bits(entry_t){rd_sel[i]}});
    end
  end
  assign rd_ok = |rd_sel;

  always_comb begin
    cnt_nxt = cnt_r;
    ok      = 1'b0;
    case (op_r)
      OP_APPEND: begin
        ok = has_room;
        if (has_room) cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_REMOVE: begin
        ok = found;
        if (found) cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_READ: begin
        ok = rd_ok;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    if (apply_go) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = '0;
      out_data_nxt[0]     = ok;
      out_data_nxt[7:1]   = ECNT_W'(cnt_nxt);
      if (op_r == OP_READ) begin
        out_data_nxt[39:8]   = rd_entry.key;
        out_data_nxt[103:40] = rd_entry.payload;
      end
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (apply_go) cnt_r <= cnt_nxt;
    end
  end

  // Hold the command and the result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= op_t'(in_tuser);
      key_r <= in_tdata[31:0];
      pay_r <= in_tdata[95:32];
      idx_r <= in_tdata[101:96];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_vec))
    else $error("more than one slot loaded");

  a_out_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_APPLY))
    else $error("result appeared outside the apply step");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && op_r == OP_REMOVE && found) |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("remove did not shrink the list");

  a_shift_needs_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    !((|shift_vec) && (|load_vec)))
    else $error("load and shift in the same cycle");

endmodule : keyed_array_list_unit

`default_nettype wire

// File: dv/testbench.sv
// Self-checking stream testbench for the keyed array list unit.
`timescale 1ns / 1ps

module testbench;
  import kal_pkg::*;

  localparam int CAPACITY = 64;

  typedef struct packed {
    logic              success;
    logic [ECNT_W-1:0] count;
    logic [KEY_W-1:0]  rkey;
    logic [PAY_W-1:0]  rpay;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = OP_NOP;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  // Shadow copy of the list, updated when an item transfers.
  logic [KEY_W-1:0] list_keys[CAPACITY];
  logic [PAY_W-1:0] list_pays[CAPACITY];
  int list_count = 0;

  list_result_t pending_results[$];
  logic [KEY_W-1:0] key_pool[16];
  int count_target = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_len = 0;
  int error_count = 0;

  keyed_array_list_unit #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic list_result_t apply_list_op(op_t op, logic [KEY_W-1:0] key,
                                                 logic [PAY_W-1:0] pay,
                                                 logic [IDX_W-1:0] idx);
    list_result_t r;
    int pos;
    int i;
    r = '0;
    case (op)
      OP_APPEND: begin
        if (list_count < CAPACITY) begin
          list_keys[list_count] = key;
          list_pays[list_count] = pay;
          list_count++;
          r.success = 1'b1;
        end
      end
      OP_REMOVE: begin
        pos = -1;
        for (i = 0; i < list_count; i++)
          if (pos < 0 && list_keys[i] == key) pos = i;
        if (pos >= 0) begin
          // close the gap: later entries move down one place
          for (i = pos; i < list_count - 1; i++) begin
            list_keys[i] = list_keys[i + 1];
            list_pays[i] = list_pays[i + 1];
          end
          list_count--;
          r.success = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(idx) < list_count) begin
          r.rkey = list_keys[idx];
          r.rpay = list_pays[idx];
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = ECNT_W'(list_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
    $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
    error_count++;
  endtask

  // Leave tvalid high after a transfer; only an idle gap lowers it.
  task automatic send_list_op(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
                              logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, idx, pay, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, key, pay, idx));
  endtask

  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.success = out_tdata[0];
      got.count   = out_tdata[7:1];
      got.rkey    = out_tdata[39:8];
      got.rpay    = out_tdata[103:40];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got.rpay);
      end else begin
        want = pending_results.pop_front();
        if (got.success !== want.success)
          report_mismatch("success", PAY_W'(want.success), PAY_W'(got.success));
        if (got.count !== want.count)
          report_mismatch("entry_count", PAY_W'(want.count), PAY_W'(got.count));
        if (got.rkey !== want.rkey)
          report_mismatch("read_key", PAY_W'(want.rkey), PAY_W'(got.rkey));
        if (got.rpay !== want.rpay) report_mismatch("read_payload", want.rpay, got.rpay);
      end
    end
  end

  function automatic logic [PAY_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // empty list: every operation fails
    send_list_op(OP_READ, 32'h0, '0, 6'd0);
    send_list_op(OP_REMOVE, 32'h0, '0, 6'd0);
    send_list_op(OP_NOP, 32'hFFFF_FFFF, '1, 6'd63);
    send_list_op(OP_APPEND, 32'h0, 64'h0, 6'd0);
    send_list_op(OP_APPEND, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
    send_list_op(OP_APPEND, 32'h5, 64'h0123_4567_89AB_CDEF, 6'd0);
    // duplicate key: a remove must take the first one only
    send_list_op(OP_APPEND, 32'h5, 64'hFEDC_BA98_7654_3210, 6'd0);
    send_list_op(OP_APPEND, 32'h7, 64'hA5A5_5A5A_A5A5_5A5A, 6'd0);
    send_list_op(OP_READ, 32'h0, '0, 6'd0);
    send_list_op(OP_READ, 32'h0, '0, 6'd1);
    send_list_op(OP_READ, 32'h0, '0, 6'd3);
    send_list_op(OP_READ, 32'h0, '0, 6'd4);
    send_list_op(OP_READ, 32'h0, '0, 6'd5);
    send_list_op(OP_READ, 32'hFFFF_FFFF, '1, 6'd63);
    send_list_op(OP_REMOVE, 32'h5, '0, 6'd0);
    send_list_op(OP_READ, 32'h0, '0, 6'd2);
    send_list_op(OP_REMOVE, 32'h0, '1, 6'd63);
    send_list_op(OP_REMOVE, 32'h7, '0, 6'd0);
    send_list_op(OP_REMOVE, 32'h0001_2345, '0, 6'd0);
    send_list_op(OP_READ, 32'h0, '0, 6'd2);
    send_list_op(OP_NOP, 32'h0, '0, 6'd0);
    send_list_op(OP_READ, 32'h0, '0, 6'd0);
  endtask

  task automatic test_fill_list();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    while (list_count < CAPACITY)
      send_list_op(OP_APPEND, $urandom, rand_payload(), 6'($urandom));
    // full list: append fails, top slot reads back
    send_list_op(OP_APPEND, $urandom, rand_payload(), 6'($urandom));
    send_list_op(OP_READ, $urandom, rand_payload(), 6'd63);
    send_list_op(OP_NOP, $urandom, rand_payload(), 6'($urandom));
    src_idle_pct = 36;
    sink_stall_pct = 36;
    while (list_count > 0) begin
      send_list_op(OP_REMOVE, list_keys[$urandom_range(list_count - 1)], rand_payload(),
                   6'($urandom));
      if ($urandom_range(3) == 0)
        send_list_op(OP_READ, $urandom, rand_payload(), 6'($urandom));
    end
    send_list_op(OP_READ, $urandom, rand_payload(), 6'd0);
  endtask

  task automatic random_list_op();
    op_t op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) op = OP_NOP;
    else if (list_count < count_target) begin
      if (roll < 60) op = OP_APPEND;
      else if (roll < 80) op = OP_READ;
      else op = OP_REMOVE;
    end else if (list_count > count_target) begin
      if (roll < 60) op = OP_REMOVE;
      else if (roll < 80) op = OP_READ;
      else op = OP_APPEND;
    end else begin
      if (roll < 35) op = OP_APPEND;
      else if (roll < 70) op = OP_REMOVE;
      else op = OP_READ;
    end
    // favor keys already in the list so removes mostly hit
    if (op == OP_REMOVE && list_count > 0 && $urandom_range(9) < 7)
      key = list_keys[$urandom_range(list_count - 1)];
    else if ($urandom_range(4) == 0)
      key = $urandom;
    else
      key = key_pool[$urandom_range(15)];
    if (op == OP_READ && list_count > 0 && $urandom_range(3) != 0)
      idx = IDX_W'($urandom_range(list_count - 1));
    else
      idx = IDX_W'($urandom);
    send_list_op(op, key, rand_payload(), idx);
  endtask

  task automatic test_random(int n, int src_pct, int sink_pct);
    int i;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (i = 0; i < 16; i++) key_pool[i] = $urandom;
    for (i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: count_target = 0;
          1: count_target = CAPACITY;
          default: count_target = $urandom_range(CAPACITY);
        endcase
      end
      random_list_op();
    end
  endtask

  task automatic test_backpressure();
    int i;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_len = 100;
    for (i = 0; i < 30; i++) random_list_op();
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_list();
    test_random(180, 0, 0);
    test_random(180, 52, 0);
    test_random(180, 0, 52);
    test_random(180, 36, 36);
    test_backpressure();
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_results.size() > 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
